// ----- design/uer_pkg.sv -----
// Shared types, constants and codes for the ultrasonic echo ranger.
`default_nettype none

package uer_pkg;

  localparam int TIME_WIDTH_DEF = 16;

  localparam int TRIG_W = 8;
  localparam int TICKS_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int ECHO_OUT_W = 16;
  localparam int DIST_OUT_W = 15;
  localparam int REM_W = 5;

  localparam logic [TRIG_W-1:0] TRIGGER_US_RESET = 8'd11;
  localparam logic [TICKS_W-1:0] RISE_TIMEOUT_RESET = 16'd65333;

  localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_US = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RISE_TIMEOUT = 1'd1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_ECHO = 2'd1;
  localparam logic [1:0] ST_SATURATED = 2'd2;

  // Distance is time*16/58, which reduces to time*8/29.
  localparam logic [REM_W-1:0] DIST_DIV = 5'd29;
  localparam logic [REM_W-1:0] DIST_STEP = 5'd8;

  localparam logic [ECHO_OUT_W-1:0] ECHO_OUT_MAX = 16'hFFFF;
  localparam logic [DIST_OUT_W-1:0] DIST_OUT_MAX = 15'h7FFF;

  typedef struct packed {
    logic clear;
    logic step;
  } dist_cmd_t;

  typedef struct packed {
    logic                  trig;
    logic                  busy;
    logic                  done;
    logic [1:0]            status;
    logic [ECHO_OUT_W-1:0] echo_time;
    logic [DIST_OUT_W-1:0] distance;
  } res_t;

endpackage

`default_nettype wire

// ----- design/ultrasonic_echo_ranger.sv -----
// Top level of the ultrasonic echo ranger: configuration, beat registers and handshakes.
`default_nettype none

// One input beat is one microsecond tick and yields exactly one result beat. A beat
// can be taken on every clock cycle while the output is not stalled; each one passes
// an input register, the sequencer logic and a result register in that order. The
// rate is set by the sequencer state, which is updated once per beat. The distance
// is kept as a running quotient next to the echo counter, so no divider or
// multiplier is used.
module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_write,
  input  wire  [CFG_INDEX_W-1:0] cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire                    start_req,
  input  wire                    echo_level,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic                   trigger_out,
  output logic                   busy_res,
  output logic                   done_res,
  output logic [1:0]             status,
  output logic [ECHO_OUT_W-1:0]  echo_time_us,
  output logic [DIST_OUT_W-1:0]  distance_q4
);

  logic [TRIG_W-1:0]     trigger_us;
  logic [TICKS_W-1:0]    rise_timeout_us;
  logic                  s1_valid;
  logic                  s1_start;
  logic                  s1_echo;
  logic                  adv;
  logic                  accept;
  dist_cmd_t             dist_cmd;
  logic [DIST_OUT_W-1:0] distance;
  res_t                  res;
  res_t                  out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_us <= TRIGGER_US_RESET;
      rise_timeout_us <= RISE_TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TRIGGER_US: trigger_us <= cfg_data[TRIG_W-1:0];
        CFG_RISE_TIMEOUT: rise_timeout_us <= cfg_data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_start <= start_req;
      s1_echo <= echo_level;
    end
  end

  uer_dist #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .cmd      (dist_cmd),
    .distance (distance)
  );

  uer_ctrl #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .start           (s1_start),
    .echo            (s1_echo),
    .trigger_us      (trigger_us),
    .rise_timeout_us (rise_timeout_us),
    .distance        (distance),
    .dist_cmd        (dist_cmd),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

  assign trigger_out = out_res.trig;
  assign busy_res = out_res.busy;
  assign done_res = out_res.done;
  assign status = out_res.status;
  assign echo_time_us = out_res.echo_time;
  assign distance_q4 = out_res.distance;

  a_held_beat: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid)
    else $error("A held input beat was dropped.");

  a_adv_out: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("An advanced beat did not reach the result register.");

endmodule

`default_nettype wire

// ----- design/uer_dist.sv -----
// Running quotient of echo time times 8 over 29, kept in step with the echo counter.
`default_nettype none

module uer_dist
  import uer_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  dist_cmd_t                   cmd,
  output logic [DIST_OUT_W-1:0]       distance
);

  localparam int QW = TIME_WIDTH - 1;
  localparam int QEW = QW + 1;

  logic [QW-1:0]    quot;
  logic [QW-1:0]    quot_next;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_next;
  logic [REM_W:0]   rem_sum;
  logic [QEW-1:0]   quot_ext;

  always_comb begin
    rem_sum = {1'b0, rem} + {1'b0, DIST_STEP};
    quot_next = quot;
    rem_next = rem;
    if (cmd.clear) begin
      quot_next = '0;
      rem_next = DIST_STEP;
    end else if (cmd.step) begin
      if (rem_sum >= {1'b0, DIST_DIV}) begin
        rem_next = REM_W'(rem_sum - {1'b0, DIST_DIV});
        quot_next = quot + QW'(1);
      end else begin
        rem_next = REM_W'(rem_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quot <= '0;
      rem <= '0;
    end else begin
      quot <= quot_next;
      rem <= rem_next;
    end
  end

  assign quot_ext = {1'b0, quot};
  assign distance = (quot_ext > QEW'(DIST_OUT_MAX)) ? DIST_OUT_MAX : DIST_OUT_W'(quot);

  a_rem_range: assert property (@(posedge clk) disable iff (rst) rem < DIST_DIV)
    else $error("Distance remainder left its range.");

endmodule

`default_nettype wire

// ----- design/uer_ctrl.sv -----
// Measurement sequencer: trigger, wait for echo rise, echo timing and result build.
`default_nettype none

module uer_ctrl
  import uer_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     adv,
  input  wire                     start,
  input  wire                     echo,
  input  wire  [TRIG_W-1:0]       trigger_us,
  input  wire  [TICKS_W-1:0]      rise_timeout_us,
  input  wire  [DIST_OUT_W-1:0]   distance,
  output dist_cmd_t               dist_cmd,
  output res_t                    res
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TRIG = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;
  localparam logic [1:0] PH_MEAS = 2'd3;

  localparam int TEW = TIME_WIDTH + 1;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

  logic [1:0]            phase;
  logic [1:0]            phase_next;
  logic [TICKS_W-1:0]    phase_ticks;
  logic [TICKS_W-1:0]    phase_ticks_next;
  logic [TICKS_W-1:0]    ticks_inc;
  logic [TIME_WIDTH-1:0] echo_time;
  logic [TIME_WIDTH-1:0] echo_time_next;
  logic [DIST_OUT_W-1:0] last_distance;
  logic [DIST_OUT_W-1:0] last_distance_next;
  logic [TRIG_W-1:0]     trig_len;
  logic [TICKS_W-1:0]    timeout;
  logic [TEW-1:0]        echo_ext;
  logic                  trig;
  logic                  done;
  logic [1:0]            status;

  assign trig_len = (trigger_us == '0) ? TRIG_W'(1) : trigger_us;
  assign timeout = (rise_timeout_us == '0) ? TICKS_W'(1) : rise_timeout_us;
  assign ticks_inc = phase_ticks + TICKS_W'(1);

  always_comb begin
    phase_next = phase;
    phase_ticks_next = phase_ticks;
    echo_time_next = echo_time;
    last_distance_next = last_distance;
    trig = 1'b0;
    done = 1'b0;
    status = ST_OK;
    dist_cmd = '0;
    unique case (phase)
      PH_IDLE: begin
        if (start) begin
          trig = 1'b1;
          if (trig_len == TRIG_W'(1)) begin
            phase_next = PH_WAIT;
            phase_ticks_next = '0;
          end else begin
            phase_next = PH_TRIG;
            phase_ticks_next = TICKS_W'(1);
          end
        end
      end
      PH_TRIG: begin
        trig = 1'b1;
        if (ticks_inc >= {{(TICKS_W-TRIG_W){1'b0}}, trig_len}) begin
          phase_next = PH_WAIT;
          phase_ticks_next = '0;
        end else begin
          phase_ticks_next = ticks_inc;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          phase_next = PH_MEAS;
          echo_time_next = TIME_WIDTH'(1);
          dist_cmd.clear = 1'b1;
        end else if (ticks_inc >= timeout) begin
          phase_next = PH_IDLE;
          phase_ticks_next = '0;
          echo_time_next = '0;
          last_distance_next = '0;
          done = 1'b1;
          status = ST_NO_ECHO;
        end else begin
          phase_ticks_next = ticks_inc;
        end
      end
      PH_MEAS: begin
        if (echo) begin
          if (echo_time != TIME_MAX) begin
            echo_time_next = echo_time + TIME_WIDTH'(1);
            dist_cmd.step = 1'b1;
          end
        end else begin
          phase_next = PH_IDLE;
          phase_ticks_next = '0;
          last_distance_next = distance;
          done = 1'b1;
          status = (echo_time == TIME_MAX) ? ST_SATURATED : ST_OK;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    if (!adv) begin
      dist_cmd = '0;
    end
  end

  assign echo_ext = {1'b0, echo_time_next};

  always_comb begin
    res.trig = trig;
    res.busy = (phase_next != PH_IDLE);
    res.done = done;
    res.status = status;
    res.echo_time = (echo_ext > TEW'(ECHO_OUT_MAX)) ? ECHO_OUT_MAX
                                                    : ECHO_OUT_W'(echo_time_next);
    res.distance = last_distance_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      phase_ticks <= '0;
      echo_time <= '0;
      last_distance <= '0;
    end else if (adv) begin
      phase <= phase_next;
      phase_ticks <= phase_ticks_next;
      echo_time <= echo_time_next;
      last_distance <= last_distance_next;
    end
  end

  a_meas_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_MEAS |-> echo_time != '0)
    else $error("Echo counter is zero during measurement.");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    adv && res.done |=> phase == PH_IDLE)
    else $error("Sequencer did not return to idle after completion.");

  a_trig_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_TRIG |-> phase_ticks < {{(TICKS_W-TRIG_W){1'b0}}, trig_len})
    else $error("Trigger pulse ran past its length.");

endmodule

`default_nettype wire
